>>> rtl/shtok_pkg.sv
package shtok_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [3:0] {
    KindChar        = 4'd0,
    KindWordEnd     = 4'd1,
    KindRedirIn     = 4'd2,
    KindRedirOut    = 4'd3,
    KindRedirAppend = 4'd4,
    KindPipe        = 4'd5,
    KindBackground  = 4'd6,
    KindLineDone    = 4'd7,
    KindUnterm      = 4'd8
  } tok_kind_e;

  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChPipe   = 8'h7C;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNl     = 8'h0A;

  typedef struct packed {
    logic       cmd;
    logic [7:0] char_byte;
  } tok_in_t;

  typedef struct packed {
    tok_kind_e  token_kind;
    logic [7:0] word_byte;
    logic       last_of_run;
  } tok_out_t;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] data;
  } tok_res_t;

  // results caused by one input word, cnt is 1 or 2 when queued
  typedef struct packed {
    logic [1:0] cnt;
    tok_res_t   res1;
    tok_res_t   res0;
  } tok_ent_t;

endpackage

>>> rtl/shtok_front.sv
module shtok_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  shtok_pkg::tok_in_t in_word_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output shtok_pkg::tok_ent_t q_ent_o
);
  import shtok_pkg::*;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeSquote = 2'd1,
    ModeDquote = 2'd2
  } mode_e;

  mode_e mode_q, mode_d;
  logic  esc_q, esc_d;
  logic  gt_q, gt_d;
  logic  open_q, open_d;
  logic  take;

  function automatic tok_ent_t add_res(tok_ent_t e, tok_kind_e k, logic [7:0] b);
    tok_ent_t r;
    r = e;
    case (e.cnt)
      2'd0: begin
        r.res0 = '{kind: k, data: b};
        r.cnt  = 2'd1;
      end
      2'd1: begin
        r.res1 = '{kind: k, data: b};
        r.cnt  = 2'd2;
      end
      default: r = e;
    endcase
    return r;
  endfunction

  always_comb begin
    tok_ent_t   e;
    logic [7:0] c;
    e      = '0;
    c      = in_word_i.char_byte;
    mode_d = mode_q;
    esc_d  = esc_q;
    gt_d   = gt_q;
    open_d = open_q;
    if (in_word_i.cmd) begin
      if (mode_q != ModeNormal) begin
        e = add_res(e, KindUnterm, 8'h00);
      end else begin
        if (gt_q) e = add_res(e, KindRedirOut, 8'h00);
        if (open_q) e = add_res(e, KindWordEnd, 8'h00);
        e = add_res(e, KindLineDone, 8'h00);
      end
      mode_d = ModeNormal;
      esc_d  = 1'b0;
      gt_d   = 1'b0;
      open_d = 1'b0;
    end else if (gt_q && !esc_q && c == ChGt) begin
      gt_d = 1'b0;
      e    = add_res(e, KindRedirAppend, 8'h00);
    end else begin
      if (gt_q) begin
        gt_d = 1'b0;
        e    = add_res(e, KindRedirOut, 8'h00);
      end
      if (esc_q) begin
        esc_d  = 1'b0;
        open_d = 1'b1;
        e      = add_res(e, KindChar, c);
      end else if (c == ChBslash) begin
        esc_d = 1'b1;
      end else begin
        case (mode_q)
          ModeSquote, ModeDquote: begin
            if ((mode_q == ModeSquote && c == ChSquote) ||
                (mode_q == ModeDquote && c == ChDquote)) begin
              mode_d = ModeNormal;
              open_d = 1'b0;
              if (open_q) e = add_res(e, KindWordEnd, 8'h00);
            end else begin
              open_d = 1'b1;
              e      = add_res(e, KindChar, c);
            end
          end
          default: begin
            if (c == ChSpace || c == ChTab || c == ChNl) begin
              open_d = 1'b0;
              if (open_q) e = add_res(e, KindWordEnd, 8'h00);
            end else if (c == ChSquote) begin
              mode_d = ModeSquote;
            end else if (c == ChDquote) begin
              mode_d = ModeDquote;
            end else if (c == ChLt || c == ChGt || c == ChPipe || c == ChAmp) begin
              open_d = 1'b0;
              if (open_q) e = add_res(e, KindWordEnd, 8'h00);
              if (c == ChLt) e = add_res(e, KindRedirIn, 8'h00);
              else if (c == ChPipe) e = add_res(e, KindPipe, 8'h00);
              else if (c == ChAmp) e = add_res(e, KindBackground, 8'h00);
              else gt_d = 1'b1;
            end else begin
              open_d = 1'b1;
              e      = add_res(e, KindChar, c);
            end
          end
        endcase
      end
    end
    q_ent_o = e;
  end

  assign take     = in_valid_i && !q_full_i;
  assign q_push_o = take && (q_ent_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      esc_q  <= 1'b0;
      gt_q   <= 1'b0;
      open_q <= 1'b0;
    end else if (take) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
      gt_q   <= gt_d;
      open_q <= open_d;
    end
  end

endmodule

>>> rtl/shtok_queue.sv
module shtok_queue #(
  parameter int unsigned Depth = shtok_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  shtok_pkg::tok_ent_t push_ent_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output shtok_pkg::tok_ent_t pop_ent_o
);
  import shtok_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  tok_ent_t        mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_ent_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_ent_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
      if (do_pop) rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

>>> rtl/shtok_back.sv
module shtok_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  shtok_pkg::tok_ent_t q_ent_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output shtok_pkg::tok_out_t out_word_o
);
  import shtok_pkg::*;

  tok_ent_t ent_q;
  logic     have_q;
  logic     sel_q;
  logic     last;
  logic     done;
  tok_res_t cur;

  assign last    = sel_q || (ent_q.cnt == 2'd1);
  assign done    = have_q && !out_stall_i;
  assign q_pop_o = !q_empty_i && (!have_q || (done && last));
  assign cur     = sel_q ? ent_q.res1 : ent_q.res0;

  assign out_valid_o            = have_q;
  assign out_word_o.token_kind  = cur.kind;
  assign out_word_o.word_byte   = cur.data;
  assign out_word_o.last_of_run = last;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) ent_q <= q_ent_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      sel_q  <= 1'b0;
    end else if (q_pop_o) begin
      have_q <= 1'b1;
      sel_q  <= 1'b0;
    end else if (done) begin
      if (last) begin
        have_q <= 1'b0;
        sel_q  <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/shell_command_line_tokenizer_core.sv
// Shell-style command-line tokenizer.
// Input channel: one word per byte (cmd = 0) or an end-of-line marker
// (cmd = 1), accepted when in_valid_i is high and in_stall_o is low.
// Output channel: one word per token result (char byte, word end,
// redirection, pipe, background, line done, unterminated quote), taken
// when out_valid_o is high and out_stall_i is low; last_of_run marks the
// final result of an input word. Bytes that give no result (quotes that
// open, a backslash, whitespace between words, a lone '>') emit nothing.
// Throughput: one input word per cycle while in_stall_o is low; output
// runs at one result per cycle while out_stall_i is low.
// Path: the classifier writes the queue at the edge that accepts the input
// word, and the back end then loads its output register from the queue and
// raises out_valid_o; earlier results or out_stall_i can hold the entry in
// the queue.
// A queue of QueueDepth entries sits between classifier and output stage;
// in_stall_o rises only when that queue is full, e.g. while the receiver
// holds out_stall_i. A stalled output word is held unchanged.
// Reset clears the lexer state (normal mode, no escape, no pending '>',
// no open word), empties the queue and drops out_valid_o.
module shell_command_line_tokenizer_core #(
  parameter int unsigned QueueDepth = shtok_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  shtok_pkg::tok_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output shtok_pkg::tok_out_t out_word_o
);
  import shtok_pkg::*;

  logic     q_push, q_full, q_pop, q_empty;
  tok_ent_t q_wr_ent, q_rd_ent;

  assign in_stall_o = q_full;

  shtok_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_ent_o    (q_wr_ent)
  );

  shtok_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_ent_i (q_wr_ent),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_ent_o  (q_rd_ent)
  );

  shtok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_ent_i     (q_rd_ent),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // second result of a byte follows right after the first
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_word_o.last_of_run |=> out_valid_o)
    else $error("second result missing");

  a_byte_only_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.token_kind != KindChar |-> out_word_o.word_byte == 8'h00)
    else $error("nonzero byte on non-char result");

  a_unterm_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.token_kind == KindUnterm ||
                    out_word_o.token_kind == KindLineDone) |-> out_word_o.last_of_run)
    else $error("end-of-line result not last");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with idle output");

endmodule
